@@ rtl/bpcg_pkg.sv @@
// ----------------------------------------------------------------------------
// bpcg_pkg
// Shared types, register codes and color helper functions of the bitplane
// pixel color generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpcg_pkg;

  localparam int NUM_PLANES   = 6;
  localparam int PIXELS       = 8;
  localparam int PLANE_W      = 8;
  localparam int DATA_W       = NUM_PLANES * PLANE_W;
  localparam int POS_W        = $clog2(PIXELS);
  localparam int APB_ADDR_W   = 5;
  localparam int APB_DATA_W   = 64;

  localparam logic [7:0] RED_BITS    = 8'h11;
  localparam logic [7:0] GREEN_BITS  = 8'h22;
  localparam logic [7:0] BLUE_BITS   = 8'h44;
  localparam logic [7:0] LEVEL_FULL  = 8'd255;
  localparam logic [7:0] LEVEL_HALF  = 8'd127;
  localparam logic [7:0] LEVEL_OFF   = 8'd0;
  localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PIXELS - 1);

  typedef enum logic [1:0] {
    REG_COLOR_WORDS = 2'd0,
    REG_MASK_SEL    = 2'd1,
    REG_BG_COLOR    = 2'd2,
    REG_ENABLE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0]     color_words;
    logic [2:0]            mask_sel;
    logic [7:0]            bg_color;
    logic [NUM_PLANES-1:0] enable;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       front;
    logic [2:0]       back;
    logic [POS_W-1:0] pos;
  } pix_t;

  function automatic logic [7:0] expand_mask(input logic [2:0] sel);
    logic [2:0] m;
    m = {sel[0], sel[2], sel[1]};
    return {1'b0, m, 1'b0, m};
  endfunction

  function automatic logic [7:0] channel_level(input logic [7:0] c, input logic [7:0] bits);
    logic [7:0] v;
    v = c & bits;
    if (v == bits) begin
      return LEVEL_FULL;
    end else if (v == (bits & LOW_NIBBLE)) begin
      return LEVEL_HALF;
    end
    return LEVEL_OFF;
  endfunction

  function automatic logic [7:0] layer_color(input logic [2:0] index,
                                             input logic [3*PLANE_W-1:0] words);
    logic [7:0] c;
    c = 8'h00;
    for (int j = 0; j < 3; j++) begin
      if (index[j]) begin
        c = c | words[j*PLANE_W +: PLANE_W];
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bpcg_regs.sv @@
// ----------------------------------------------------------------------------
// bpcg_regs
// APB configuration registers: plane color words, color mask select,
// background color and plane enables.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bpcg_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [bpcg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [bpcg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output bpcg_pkg::cfg_t                        cfg
);
  import bpcg_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_words <= '0;
      cfg.mask_sel    <= 3'd7;
      cfg.bg_color    <= 8'd0;
      cfg.enable      <= {NUM_PLANES{1'b1}};
    end else if (wr) begin
      case (idx)
        REG_COLOR_WORDS: cfg.color_words <= pwdata[DATA_W-1:0];
        REG_MASK_SEL:    cfg.mask_sel    <= pwdata[2:0];
        REG_BG_COLOR:    cfg.bg_color    <= pwdata[7:0];
        REG_ENABLE:      cfg.enable      <= pwdata[NUM_PLANES-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_COLOR_WORDS: prdata = APB_DATA_W'(cfg.color_words);
      REG_MASK_SEL:    prdata = APB_DATA_W'(cfg.mask_sel);
      REG_BG_COLOR:    prdata = APB_DATA_W'(cfg.bg_color);
      REG_ENABLE:      prdata = APB_DATA_W'(cfg.enable);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/bpcg_serializer.sv @@
// ----------------------------------------------------------------------------
// bpcg_serializer
// Holds one group of six enabled plane bytes and issues one pixel of layer
// index bits per cycle, bit 0 of each plane byte first. Takes the next group
// as the last pixel of the current one is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcg_serializer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [bpcg_pkg::DATA_W-1:0]     plane_data,
  input  wire logic [bpcg_pkg::NUM_PLANES-1:0] enable,
  output bpcg_pkg::pix_t                       pix
);
  import bpcg_pkg::*;

  logic [DATA_W-1:0] planes;
  logic [DATA_W-1:0] planes_next;
  logic [POS_W-1:0]  count;
  logic              active;
  logic              take;
  logic [NUM_PLANES-1:0] bits;

  assign busy = active && (count != LAST_POS);
  assign take = start && !busy;

  always_comb begin
    for (int k = 0; k < NUM_PLANES; k++) begin
      planes_next[k*PLANE_W +: PLANE_W] =
        enable[k] ? plane_data[k*PLANE_W +: PLANE_W] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count  <= '0;
    end else if (take) begin
      active <= 1'b1;
      count  <= '0;
    end else if (active) begin
      count <= count + POS_W'(1);
      if (count == LAST_POS) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      planes <= planes_next;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PLANES; k++) begin
      bits[k] = planes[k*PLANE_W + int'(count)];
    end
  end

  assign pix.valid = active;
  assign pix.front = bits[2:0];
  assign pix.back  = bits[5:3];
  assign pix.pos   = count;

  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    take |=> (active && count == '0))
    else $error("accepted group not loaded at pixel zero");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (active && count != LAST_POS) |=> (active && count == $past(count) + POS_W'(1)))
    else $error("pixel counter skipped or stopped mid-group");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (active && count == LAST_POS && !start) |=> !active)
    else $error("serializer stayed active after the last pixel");

endmodule

`default_nettype wire

@@ rtl/bpcg_color_pipe.sv @@
// ----------------------------------------------------------------------------
// bpcg_color_pipe
// Three-stage pixel color pipeline: layer select and color OR, color mask,
// channel level decode into the registered result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcg_color_pipe (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  bpcg_pkg::pix_t                   pix,
  input  bpcg_pkg::cfg_t                   cfg,
  output logic                             strobe,
  output logic [7:0]                       red_level,
  output logic [7:0]                       green_level,
  output logic [7:0]                       blue_level,
  output logic [bpcg_pkg::POS_W-1:0]       pixel_position,
  output logic                             last_pixel
);
  import bpcg_pkg::*;

  logic             s1_valid;
  logic [7:0]       s1_color;
  logic             s1_layer;
  logic [POS_W-1:0] s1_pos;
  logic [7:0]       s1_color_next;
  logic             s1_layer_next;

  logic             s2_valid;
  logic [7:0]       s2_color;
  logic [POS_W-1:0] s2_pos;
  logic [7:0]       s2_color_next;
  logic [7:0]       mask;

  always_comb begin
    if (pix.front != 3'd0) begin
      s1_color_next = layer_color(pix.front, cfg.color_words[3*PLANE_W-1:0]);
      s1_layer_next = 1'b1;
    end else if (pix.back != 3'd0) begin
      s1_color_next = layer_color(pix.back, cfg.color_words[DATA_W-1:3*PLANE_W]);
      s1_layer_next = 1'b1;
    end else begin
      s1_color_next = cfg.bg_color;
      s1_layer_next = 1'b0;
    end
  end

  assign mask = expand_mask(cfg.mask_sel);

  always_comb begin
    if (s1_layer && ((s1_color & mask) != 8'h00)) begin
      s2_color_next = s1_color & mask;
    end else begin
      s2_color_next = s1_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      s1_valid <= pix.valid;
      s2_valid <= s1_valid;
      strobe   <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_color       <= s1_color_next;
    s1_layer       <= s1_layer_next;
    s1_pos         <= pix.pos;
    s2_color       <= s2_color_next;
    s2_pos         <= s1_pos;
    red_level      <= channel_level(s2_color, RED_BITS);
    green_level    <= channel_level(s2_color, GREEN_BITS);
    blue_level     <= channel_level(s2_color, BLUE_BITS);
    pixel_position <= s2_pos;
    last_pixel     <= (s2_pos == LAST_POS);
  end

  a_levels_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((red_level == LEVEL_FULL || red_level == LEVEL_HALF || red_level == LEVEL_OFF)
             && (green_level == LEVEL_FULL || green_level == LEVEL_HALF
                 || green_level == LEVEL_OFF)
             && (blue_level == LEVEL_FULL || blue_level == LEVEL_HALF
                 || blue_level == LEVEL_OFF)))
    else $error("channel level outside the three intensities");

  a_position_chain: assert property (@(posedge clk) disable iff (rst)
    (strobe && pixel_position != '0) |->
      ($past(strobe) && $past(pixel_position) == pixel_position - POS_W'(1)))
    else $error("pixel positions out of order");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (last_pixel == (pixel_position == LAST_POS)))
    else $error("last pixel flag disagrees with pixel position");

endmodule

`default_nettype wire

@@ rtl/bitplane_pixel_color_generator_top.sv @@
// ----------------------------------------------------------------------------
// bitplane_pixel_color_generator_top
// Turns groups of six bitplane bytes into eight RGB pixels, one per cycle.
// ----------------------------------------------------------------------------
// The first pixel strobes once it has passed the s1, s2 and output registers.
// Throughput: one pixel per cycle while a group is held, set by the single
//   pixel output port; busy drops on the cycle the last pixel issues.
// Results cannot be stalled; the strobe marks each pixel for one cycle.
// Reset (rst, synchronous): clears pipeline valids and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module bitplane_pixel_color_generator_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [bpcg_pkg::DATA_W-1:0]      plane_data,
  output logic                                  strobe,
  output logic [7:0]                            red_level,
  output logic [7:0]                            green_level,
  output logic [7:0]                            blue_level,
  output logic [bpcg_pkg::POS_W-1:0]            pixel_position,
  output logic                                  last_pixel,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bpcg_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [bpcg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [bpcg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import bpcg_pkg::*;

  cfg_t cfg;
  pix_t pix;

  bpcg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpcg_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .plane_data (plane_data),
    .enable     (cfg.enable),
    .pix        (pix)
  );

  bpcg_color_pipe u_color_pipe (
    .clk            (clk),
    .rst            (rst),
    .pix            (pix),
    .cfg            (cfg),
    .strobe         (strobe),
    .red_level      (red_level),
    .green_level    (green_level),
    .blue_level     (blue_level),
    .pixel_position (pixel_position),
    .last_pixel     (last_pixel)
  );

endmodule

`default_nettype wire
